// ===== design/ebpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ebpf_pkg
// Shared types, constants and opcode fields of the eBPF instruction executor.
// ----------------------------------------------------------------------------
package ebpf_pkg;

  // Memory geometry and address map
  localparam int unsigned STACK_BYTES = 512;
  localparam int unsigned CTX_BYTES   = 256;
  localparam logic [63:0] STACK_BASE  = 64'd65536;

  localparam int unsigned STK_AW = $clog2(STACK_BYTES);
  localparam int unsigned CTX_AW = $clog2(CTX_BYTES);
  localparam int unsigned MEM_OW = (STK_AW > CTX_AW) ? STK_AW : CTX_AW;

  // Register file
  localparam int unsigned NUM_REGS = 11;
  localparam logic [3:0]  LAST_REG = 4'(NUM_REGS - 1);
  localparam logic [63:0] R10_RESET = STACK_BASE + 64'(STACK_BYTES);

  // Host actions
  localparam logic [1:0] ACT_EXEC   = 2'd0;
  localparam logic [1:0] ACT_SETREG = 2'd1;
  localparam logic [1:0] ACT_CTXWR  = 2'd2;
  localparam logic [1:0] ACT_RDREG  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_EXIT  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;
  localparam logic [1:0] ST_CALL  = 2'd3;

  // Instruction classes
  localparam logic [2:0] CLS_LD    = 3'd1;
  localparam logic [2:0] CLS_ST    = 3'd2;
  localparam logic [2:0] CLS_STX   = 3'd3;
  localparam logic [2:0] CLS_ALU   = 3'd4;
  localparam logic [2:0] CLS_JMP   = 3'd5;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  localparam logic [2:0] MODE_MEM = 3'b011;

  // ALU operation codes (opcode bits 7:4)
  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_DIV  = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LSH  = 4'h6;
  localparam logic [3:0] OP_RSH  = 4'h7;
  localparam logic [3:0] OP_NEG  = 4'h8;
  localparam logic [3:0] OP_MOD  = 4'h9;
  localparam logic [3:0] OP_XOR  = 4'ha;
  localparam logic [3:0] OP_MOV  = 4'hb;
  localparam logic [3:0] OP_ARSH = 4'hc;
  localparam logic [3:0] OP_END  = 4'hd;

  // Jump condition codes (opcode bits 7:4)
  localparam logic [3:0] J_JA   = 4'h0;
  localparam logic [3:0] J_EQ   = 4'h1;
  localparam logic [3:0] J_GT   = 4'h2;
  localparam logic [3:0] J_GE   = 4'h3;
  localparam logic [3:0] J_SET  = 4'h4;
  localparam logic [3:0] J_NE   = 4'h5;
  localparam logic [3:0] J_SGT  = 4'h6;
  localparam logic [3:0] J_SGE  = 4'h7;
  localparam logic [3:0] J_CALL = 4'h8;
  localparam logic [3:0] J_EXIT = 4'h9;
  localparam logic [3:0] J_LT   = 4'ha;
  localparam logic [3:0] J_LE   = 4'hb;
  localparam logic [3:0] J_SLT  = 4'hc;
  localparam logic [3:0] J_SLE  = 4'hd;

  // Whole opcodes with special handling
  localparam logic [7:0] OPC_LDDW = 8'h18;
  localparam logic [7:0] OPC_JA   = 8'h05;
  localparam logic [7:0] OPC_CALL = 8'h85;
  localparam logic [7:0] OPC_EXIT = 8'h95;

  // Item kind as sorted by the front end
  typedef enum logic [2:0] {
    K_SETREG,
    K_CTXWR,
    K_RDREG,
    K_ALU,
    K_MEM,
    K_LDDW,
    K_JMP,
    K_FAULT
  } kind_e;

  // One queued item
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         opcode;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic signed [15:0] offset;
    logic signed [31:0] imm;
    logic signed [31:0] imm_high;
    logic [63:0]        value;
    logic [7:0]         ctx_index;
  } item_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

// ===== design/ebpf_front.sv =====
// ----------------------------------------------------------------------------
// ebpf_front
// Accepts host items, sorts them by kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module ebpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [7:0]          opcode_i,
  input  logic [3:0]          dst_reg_i,
  input  logic [3:0]          src_reg_i,
  input  logic signed [15:0]  offset_i,
  input  logic signed [31:0]  imm_i,
  input  logic signed [31:0]  imm_high_i,
  input  logic [63:0]         value_i,
  input  logic [7:0]          ctx_index_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output ebpf_pkg::item_t     q_item_o
);

  ebpf_pkg::item_t                 item_in;
  ebpf_pkg::kind_e                 kind;
  ebpf_pkg::item_t                 mem_q [ebpf_pkg::QUEUE_DEPTH];
  logic [ebpf_pkg::QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ebpf_pkg::QUEUE_AW:0]     cnt_q, cnt_d;
  logic                            push, pop;

  // Classify the incoming item
  always_comb begin
    kind = ebpf_pkg::K_FAULT;
    unique case (action_i)
      ebpf_pkg::ACT_SETREG: kind = ebpf_pkg::K_SETREG;
      ebpf_pkg::ACT_CTXWR:  kind = ebpf_pkg::K_CTXWR;
      ebpf_pkg::ACT_RDREG:  kind = ebpf_pkg::K_RDREG;
      default: begin
        if (opcode_i == ebpf_pkg::OPC_LDDW) begin
          kind = ebpf_pkg::K_LDDW;
        end else begin
          unique case (opcode_i[2:0])
            ebpf_pkg::CLS_ALU, ebpf_pkg::CLS_ALU64: kind = ebpf_pkg::K_ALU;
            ebpf_pkg::CLS_LD, ebpf_pkg::CLS_ST,
            ebpf_pkg::CLS_STX:                      kind = ebpf_pkg::K_MEM;
            ebpf_pkg::CLS_JMP:                      kind = ebpf_pkg::K_JMP;
            default:                                kind = ebpf_pkg::K_FAULT;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    item_in.kind      = kind;
    item_in.opcode    = opcode_i;
    item_in.dst_reg   = dst_reg_i;
    item_in.src_reg   = src_reg_i;
    item_in.offset    = offset_i;
    item_in.imm       = imm_i;
    item_in.imm_high  = imm_high_i;
    item_in.value     = value_i;
    item_in.ctx_index = ctx_index_i;
  end

  // Queue control
  assign in_ready_o = (cnt_q != (ebpf_pkg::QUEUE_AW + 1)'(ebpf_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== design/ebpf_back.sv =====
// ----------------------------------------------------------------------------
// ebpf_back
// Executes queued items: register file, stack and context memories,
// shared multiplier, bit-serial divider and the result register.
// ----------------------------------------------------------------------------
module ebpf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [8:0]         ctx_len_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  ebpf_pkg::item_t    q_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic [1:0]         status_o,
  output logic [63:0]        result_value_o,
  output logic [31:0]        helper_index_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MEM  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // Byte reversal of a full word
  function automatic logic [63:0] swap8(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  logic [2:0]   state_q, state_d;
  ebpf_pkg::item_t it_q, it_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [15:0]  pc_q, pc_d;
  logic [63:0]  rf_q [ebpf_pkg::NUM_REGS];

  // Result holding and output register
  logic [1:0]   res_st_q, res_st_d, out_st_q, out_st_d;
  logic [63:0]  res_rv_q, res_rv_d, out_rv_q, out_rv_d;
  logic [31:0]  res_hl_q, res_hl_d, out_hl_q, out_hl_d;
  logic [15:0]  out_pc_q, out_pc_d;
  logic         out_vld_q, out_vld_d;

  // Multiply and divide
  logic [1:0]   mstep_q, mstep_d;
  logic [63:0]  prod_q, prod_d, acc_q, acc_d;
  logic [31:0]  mul_x, mul_y;
  logic [64:0]  rem_q, rem_d, dshift;
  logic [63:0]  quo_q, quo_d;
  logic [5:0]   dcnt_q, dcnt_d;
  logic         qbit;

  // Memory access sequencing
  logic                        region_q, region_d;
  logic [ebpf_pkg::MEM_OW-1:0] moff_q, moff_d, maddr;
  logic [3:0]                  msize_q, msize_d;
  logic [2:0]                  mcnt_q, mcnt_d;
  logic                        mph_q, mph_d;
  logic [63:0]                 ld_q, ld_d, sd_q, sd_d, ld_new;
  logic                        mlast;
  logic [7:0]                  rd_byte;

  // Memory ports
  logic [7:0]                  stk_mem [ebpf_pkg::STACK_BYTES];
  logic [7:0]                  ctx_mem [ebpf_pkg::CTX_BYTES];
  logic [ebpf_pkg::CTX_BYTES-1:0] ctx_vld_q;
  logic                        stk_we, ctx_we;
  logic [ebpf_pkg::STK_AW-1:0] stk_wa;
  logic [ebpf_pkg::CTX_AW-1:0] ctx_wa;
  logic [7:0]                  stk_wd, ctx_wd, stk_rd_q, ctx_rd_q;
  logic                        ctx_rv_q;

  // Register file write port
  logic         rf_we;
  logic [3:0]   rf_wa;
  logic [63:0]  rf_wd;

  // Instruction decode
  logic [7:0]   op;
  logic [2:0]   cls;
  logic [3:0]   code;
  logic         use_src, wide, dst_ok, src_ok;
  logic [63:0]  imm64, off64, opb, am, bm, alu_r, sw_r, wmask;
  logic [5:0]   sh;
  logic         taken;
  logic [63:0]  addr, lim, srel, size64;
  logic [3:0]   msz;
  logic         in_ctx, in_stk;

  // Completion
  logic         fin, ex_fault;
  logic [1:0]   fin_st;
  logic [63:0]  fin_rv;
  logic [31:0]  fin_hl;
  logic [15:0]  fin_pc;

  assign q_ready_o = (state_q == S_IDLE);

  // Field decode of the current item
  always_comb begin
    op      = it_q.opcode;
    cls     = op[2:0];
    code    = op[7:4];
    use_src = op[3];
    wide    = (cls == ebpf_pkg::CLS_ALU64);
    dst_ok  = (it_q.dst_reg <= ebpf_pkg::LAST_REG);
    src_ok  = (it_q.src_reg <= ebpf_pkg::LAST_REG);
    imm64   = {{32{it_q.imm[31]}}, it_q.imm};
    off64   = {{48{it_q.offset[15]}}, it_q.offset};
    opb     = use_src ? b_q : imm64;
    wmask   = wide ? '1 : {32'd0, 32'hffff_ffff};
    am      = a_q & wmask;
    bm      = opb & wmask;
    sh      = wide ? bm[5:0] : {1'b0, bm[4:0]};
  end

  // Combinational ALU operations
  always_comb begin
    case (code)
      ebpf_pkg::OP_ADD:  alu_r = am + bm;
      ebpf_pkg::OP_SUB:  alu_r = am - bm;
      ebpf_pkg::OP_OR:   alu_r = am | bm;
      ebpf_pkg::OP_AND:  alu_r = am & bm;
      ebpf_pkg::OP_LSH:  alu_r = am << sh;
      ebpf_pkg::OP_RSH:  alu_r = am >> sh;
      ebpf_pkg::OP_NEG:  alu_r = 64'd0 - am;
      ebpf_pkg::OP_XOR:  alu_r = am ^ bm;
      ebpf_pkg::OP_MOV:  alu_r = bm;
      ebpf_pkg::OP_ARSH: alu_r = wide ? 64'($signed(am) >>> sh)
                                      : 64'($signed({{32{am[31]}}, am[31:0]}) >>> sh);
      default:           alu_r = am;
    endcase
    alu_r = alu_r & wmask;
  end

  // Byte swap and truncation
  always_comb begin
    sw_r = a_q;
    if (it_q.imm == 32'sd16) begin
      sw_r = use_src ? (swap8(a_q) >> 48) : {48'd0, a_q[15:0]};
    end else if (it_q.imm == 32'sd32) begin
      sw_r = use_src ? (swap8(a_q) >> 32) : {32'd0, a_q[31:0]};
    end else if (it_q.imm == 32'sd64) begin
      sw_r = use_src ? swap8(a_q) : a_q;
    end
  end

  // Branch condition
  always_comb begin
    case (code)
      ebpf_pkg::J_EQ:  taken = (a_q == opb);
      ebpf_pkg::J_GT:  taken = (a_q > opb);
      ebpf_pkg::J_GE:  taken = (a_q >= opb);
      ebpf_pkg::J_SET: taken = ((a_q & opb) != 64'd0);
      ebpf_pkg::J_NE:  taken = (a_q != opb);
      ebpf_pkg::J_SGT: taken = ($signed(a_q) > $signed(opb));
      ebpf_pkg::J_SGE: taken = ($signed(a_q) >= $signed(opb));
      ebpf_pkg::J_LT:  taken = (a_q < opb);
      ebpf_pkg::J_LE:  taken = (a_q <= opb);
      ebpf_pkg::J_SLT: taken = ($signed(a_q) < $signed(opb));
      default:         taken = ($signed(a_q) <= $signed(opb));
    endcase
  end

  // Region check of a load or store
  always_comb begin
    case (op[4:3])
      2'd0:    msz = 4'd4;
      2'd1:    msz = 4'd2;
      2'd2:    msz = 4'd1;
      default: msz = 4'd8;
    endcase
    size64 = {60'd0, msz};
    addr   = ((cls == ebpf_pkg::CLS_LD) ? b_q : a_q) + off64;
    lim    = ({55'd0, ctx_len_i} > 64'(ebpf_pkg::CTX_BYTES)) ? 64'(ebpf_pkg::CTX_BYTES)
                                                             : {55'd0, ctx_len_i};
    srel   = addr - ebpf_pkg::STACK_BASE;
    in_ctx = (addr < lim) && (size64 <= lim - addr);
    in_stk = (addr >= ebpf_pkg::STACK_BASE) && (srel < 64'(ebpf_pkg::STACK_BYTES)) &&
             (size64 <= 64'(ebpf_pkg::STACK_BYTES) - srel);
  end

  // Shared 32x32 multiplier and divider step
  always_comb begin
    mul_x  = (mstep_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    mul_y  = (mstep_q == 2'd1) ? b_q[63:32] : b_q[31:0];
    prod_d = 64'(mul_x) * 64'(mul_y);
    dshift = {rem_q[63:0], quo_q[63]};
    qbit   = (dshift >= {1'b0, b_q});
  end

  // Memory byte address and data
  always_comb begin
    maddr   = moff_q + ebpf_pkg::MEM_OW'(mcnt_q);
    rd_byte = region_q ? stk_rd_q : (ctx_rv_q ? ctx_rd_q : 8'd0);
    ld_new  = ld_q;
    ld_new[{mcnt_q, 3'b000} +: 8] = rd_byte;
    mlast   = ((4'(mcnt_q) + 4'd1) == msize_q);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    it_d      = it_q;
    a_d       = a_q;
    b_d       = b_q;
    pc_d      = pc_q;
    res_st_d  = res_st_q;
    res_rv_d  = res_rv_q;
    res_hl_d  = res_hl_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_pc_d  = out_pc_q;
    out_st_d  = out_st_q;
    out_rv_d  = out_rv_q;
    out_hl_d  = out_hl_q;
    mstep_d   = mstep_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    region_d  = region_q;
    moff_d    = moff_q;
    msize_d   = msize_q;
    mcnt_d    = mcnt_q;
    mph_d     = mph_q;
    ld_d      = ld_q;
    sd_d      = sd_q;
    rf_we     = 1'b0;
    rf_wa     = it_q.dst_reg;
    rf_wd     = alu_r;
    stk_we    = 1'b0;
    stk_wa    = maddr[ebpf_pkg::STK_AW-1:0];
    stk_wd    = sd_q[{mcnt_q, 3'b000} +: 8];
    ctx_we    = 1'b0;
    ctx_wa    = maddr[ebpf_pkg::CTX_AW-1:0];
    ctx_wd    = sd_q[{mcnt_q, 3'b000} +: 8];
    fin       = 1'b0;
    ex_fault  = 1'b0;
    fin_st    = ebpf_pkg::ST_RUN;
    fin_rv    = 64'd0;
    fin_hl    = 32'd0;
    fin_pc    = pc_q;

    unique case (state_q)
      // Take the next item and read its two operand registers
      S_IDLE: begin
        if (q_valid_i) begin
          it_d    = q_item_i;
          a_d     = (q_item_i.dst_reg <= ebpf_pkg::LAST_REG) ? rf_q[q_item_i.dst_reg] : '0;
          b_d     = (q_item_i.src_reg <= ebpf_pkg::LAST_REG) ? rf_q[q_item_i.src_reg] : '0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (it_q.kind)
          ebpf_pkg::K_SETREG: begin
            fin   = 1'b1;
            rf_we = dst_ok;
            rf_wd = it_q.value;
          end
          ebpf_pkg::K_CTXWR: begin
            fin    = 1'b1;
            ctx_we = ({56'd0, it_q.ctx_index} < 64'(ebpf_pkg::CTX_BYTES));
            ctx_wa = ebpf_pkg::CTX_AW'(it_q.ctx_index);
            ctx_wd = it_q.value[7:0];
          end
          ebpf_pkg::K_RDREG: begin
            fin    = 1'b1;
            fin_rv = a_q;
          end
          ebpf_pkg::K_ALU: begin
            if (!dst_ok) begin
              ex_fault = 1'b1;
            end else if (code == ebpf_pkg::OP_END) begin
              if (wide) begin
                ex_fault = 1'b1;
              end else begin
                fin    = 1'b1;
                rf_we  = 1'b1;
                rf_wd  = sw_r;
                fin_pc = pc_q + 16'd1;
              end
            end else if (code == ebpf_pkg::OP_NEG && use_src) begin
              ex_fault = 1'b1;
            end else if (use_src && !src_ok) begin
              ex_fault = 1'b1;
            end else begin
              case (code)
                ebpf_pkg::OP_MUL: begin
                  a_d     = am;
                  b_d     = bm;
                  mstep_d = 2'd0;
                  state_d = S_MUL;
                end
                ebpf_pkg::OP_DIV, ebpf_pkg::OP_MOD: begin
                  if (bm == 64'd0) begin
                    ex_fault = 1'b1;
                  end else begin
                    a_d     = am;
                    b_d     = bm;
                    rem_d   = '0;
                    quo_d   = am;
                    dcnt_d  = '0;
                    state_d = S_DIV;
                  end
                end
                4'he, 4'hf: ex_fault = 1'b1;
                default: begin
                  fin    = 1'b1;
                  rf_we  = 1'b1;
                  fin_pc = pc_q + 16'd1;
                end
              endcase
            end
          end
          ebpf_pkg::K_MEM: begin
            if (op[7:5] != ebpf_pkg::MODE_MEM || !dst_ok ||
                (cls != ebpf_pkg::CLS_ST && !src_ok) || !(in_ctx || in_stk)) begin
              ex_fault = 1'b1;
            end else begin
              region_d = !in_ctx;
              moff_d   = in_ctx ? ebpf_pkg::MEM_OW'(addr[ebpf_pkg::CTX_AW-1:0])
                                : ebpf_pkg::MEM_OW'(srel[ebpf_pkg::STK_AW-1:0]);
              msize_d  = msz;
              mcnt_d   = '0;
              mph_d    = 1'b0;
              ld_d     = '0;
              sd_d     = (cls == ebpf_pkg::CLS_ST) ? imm64 : b_q;
              state_d  = S_MEM;
            end
          end
          ebpf_pkg::K_LDDW: begin
            if (!dst_ok) begin
              ex_fault = 1'b1;
            end else begin
              fin    = 1'b1;
              rf_we  = 1'b1;
              rf_wd  = {it_q.imm_high, it_q.imm};
              fin_pc = pc_q + 16'd2;
            end
          end
          ebpf_pkg::K_JMP: begin
            if (op == ebpf_pkg::OPC_JA) begin
              fin    = 1'b1;
              fin_pc = pc_q + 16'd1 + it_q.offset;
            end else if (op == ebpf_pkg::OPC_CALL) begin
              fin    = 1'b1;
              fin_st = ebpf_pkg::ST_CALL;
              fin_hl = it_q.imm;
              fin_pc = pc_q + 16'd1;
            end else if (op == ebpf_pkg::OPC_EXIT) begin
              fin    = 1'b1;
              fin_st = ebpf_pkg::ST_EXIT;
              fin_rv = rf_q[0];
            end else if (code == ebpf_pkg::J_JA || code == ebpf_pkg::J_CALL ||
                         code == ebpf_pkg::J_EXIT || code >= 4'he ||
                         !dst_ok || (use_src && !src_ok)) begin
              ex_fault = 1'b1;
            end else begin
              fin    = 1'b1;
              fin_pc = taken ? pc_q + 16'd1 + it_q.offset : pc_q + 16'd1;
            end
          end
          default: ex_fault = 1'b1;
        endcase
      end

      // Low word of the product over three partial products
      S_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd1) begin
          acc_d = prod_q;
        end else if (mstep_q == 2'd2) begin
          acc_d = acc_q + {prod_q[31:0], 32'd0};
        end else if (mstep_q == 2'd3) begin
          fin    = 1'b1;
          rf_we  = 1'b1;
          rf_wd  = (acc_q + {prod_q[31:0], 32'd0}) & wmask;
          fin_pc = pc_q + 16'd1;
        end
      end

      // Restoring division, one quotient bit a cycle
      S_DIV: begin
        rem_d  = qbit ? dshift - {1'b0, b_q} : dshift;
        quo_d  = {quo_q[62:0], qbit};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          fin    = 1'b1;
          rf_we  = 1'b1;
          rf_wd  = ((code == ebpf_pkg::OP_DIV) ? quo_d : rem_d[63:0]) & wmask;
          fin_pc = pc_q + 16'd1;
        end
      end

      // One byte per cycle for stores; loads wait on the registered read of each byte
      S_MEM: begin
        if (cls == ebpf_pkg::CLS_LD) begin
          if (!mph_q) begin
            mph_d = 1'b1;
          end else begin
            ld_d   = ld_new;
            mph_d  = 1'b0;
            mcnt_d = mcnt_q + 3'd1;
            if (mlast) begin
              fin    = 1'b1;
              rf_we  = 1'b1;
              rf_wd  = ld_new;
              fin_pc = pc_q + 16'd1;
            end
          end
        end else begin
          stk_we = region_q;
          ctx_we = !region_q;
          mcnt_d = mcnt_q + 3'd1;
          if (mlast) begin
            fin    = 1'b1;
            fin_pc = pc_q + 16'd1;
          end
        end
      end

      // Hand the result to the output register
      S_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_pc_d  = pc_q;
          out_st_d  = res_st_q;
          out_rv_d  = res_rv_q;
          out_hl_d  = res_hl_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // A fault leaves all state alone
    if (ex_fault) begin
      fin    = 1'b1;
      rf_we  = 1'b0;
      ctx_we = 1'b0;
      fin_st = ebpf_pkg::ST_FAULT;
      fin_rv = '1;
      fin_hl = '0;
      fin_pc = pc_q;
    end

    if (fin) begin
      res_st_d = fin_st;
      res_rv_d = fin_rv;
      res_hl_d = fin_hl;
      pc_d     = fin_pc;
      state_d  = S_FIN;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      out_vld_q <= 1'b0;
      mstep_q   <= '0;
      dcnt_q    <= '0;
      mcnt_q    <= '0;
      mph_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      out_vld_q <= out_vld_d;
      mstep_q   <= mstep_d;
      dcnt_q    <= dcnt_d;
      mcnt_q    <= mcnt_d;
      mph_q     <= mph_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    it_q     <= it_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_st_q <= res_st_d;
    res_rv_q <= res_rv_d;
    res_hl_q <= res_hl_d;
    out_pc_q <= out_pc_d;
    out_st_q <= out_st_d;
    out_rv_q <= out_rv_d;
    out_hl_q <= out_hl_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    region_q <= region_d;
    moff_q   <= moff_d;
    msize_q  <= msize_d;
    ld_q     <= ld_d;
    sd_q     <= sd_d;
  end

  // Register file, r10 starts at the stack top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ebpf_pkg::NUM_REGS; i++) begin
        rf_q[i] <= (i == ebpf_pkg::NUM_REGS - 1) ? ebpf_pkg::R10_RESET : 64'd0;
      end
    end else if (rf_we && rf_wa <= ebpf_pkg::LAST_REG) begin
      rf_q[rf_wa] <= rf_wd;
    end
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[maddr[ebpf_pkg::STK_AW-1:0]];
  end

  // Context memory, unwritten bytes read as zero
  always_ff @(posedge clk_i) begin
    if (ctx_we) begin
      ctx_mem[ctx_wa] <= ctx_wd;
    end
    ctx_rd_q <= ctx_mem[maddr[ebpf_pkg::CTX_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_vld_q <= '0;
      ctx_rv_q  <= 1'b0;
    end else begin
      if (ctx_we) begin
        ctx_vld_q[ctx_wa] <= 1'b1;
      end
      ctx_rv_q <= ctx_vld_q[maddr[ebpf_pkg::CTX_AW-1:0]];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign next_pc_o      = out_pc_q;
  assign status_o       = out_st_q;
  assign result_value_o = out_rv_q;
  assign helper_index_o = out_hl_q;

endmodule

// ===== design/ebpf_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// ebpf_instruction_executor
// Executes one eBPF instruction or host register/context action per item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid_i/in_ready_o | action .. ctx_index
//  out      | output    | out_valid_o/out_ready_i | next_pc, status, result_value,
//           |           |                       | helper_index
//  cfg      | input     | cfg_valid_i/cfg_ready_o | ctx_len
//
//  A two-item queue takes items while the executor works. Most items pass
//  through operand read, execute and result hand-off in the executor;
//  multiplies, divides, modulos, loads and stores take longer, held up by
//  the shared multiplier, the one-bit divider and the single byte port of
//  each memory. The result register frees the executor while a result
//  waits. Reset clears registers (r10 to the stack top), pc, ctx_len and
//  the context memory valid bits.
// ----------------------------------------------------------------------------
module ebpf_instruction_executor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [8:0]         ctx_len_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         opcode_i,
  input  logic [3:0]         dst_reg_i,
  input  logic [3:0]         src_reg_i,
  input  logic signed [15:0] offset_i,
  input  logic signed [31:0] imm_i,
  input  logic signed [31:0] imm_high_i,
  input  logic [63:0]        value_i,
  input  logic [7:0]         ctx_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic [1:0]         status_o,
  output logic [63:0]        result_value_o,
  output logic [31:0]        helper_index_o
);

  logic [8:0]      ctx_len_q;
  logic            q_valid, q_ready;
  ebpf_pkg::item_t q_item;

  // Context length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_len_q <= '0;
    end else if (cfg_valid_i) begin
      ctx_len_q <= ctx_len_i;
    end
  end

  ebpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .opcode_i    (opcode_i),
    .dst_reg_i   (dst_reg_i),
    .src_reg_i   (src_reg_i),
    .offset_i    (offset_i),
    .imm_i       (imm_i),
    .imm_high_i  (imm_high_i),
    .value_i     (value_i),
    .ctx_index_i (ctx_index_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  ebpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctx_len_i      (ctx_len_q),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_item_i       (q_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_pc_o      (next_pc_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .helper_index_o (helper_index_o)
  );

endmodule

// ===== bench/ebpf_instruction_executor_tb.sv =====
// ----------------------------------------------------------------------------
// ebpf_instruction_executor_tb
// Self-checking bench: directed and random items are sent to the executor,
// an in-bench eBPF machine predicts each result and a monitor compares them.
// ----------------------------------------------------------------------------
module ebpf_instruction_executor_tb;
  import ebpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  opcode;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [15:0] offs;
    logic [31:0] imm;
    logic [31:0] imm_hi;
    logic [63:0] value;
    logic [7:0]  cidx;
  } instr_t;

  typedef struct {
    logic [15:0] pc;
    logic [1:0]  status;
    logic [63:0] rv;
    logic [31:0] helper;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [8:0]         ctx_len_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic [7:0]         opcode_i;
  logic [3:0]         dst_reg_i;
  logic [3:0]         src_reg_i;
  logic signed [15:0] offset_i;
  logic signed [31:0] imm_i;
  logic signed [31:0] imm_high_i;
  logic [63:0]        value_i;
  logic [7:0]         ctx_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        next_pc_o;
  logic [1:0]         status_o;
  logic [63:0]        result_value_o;
  logic [31:0]        helper_index_o;

  ebpf_instruction_executor dut (.*);

  // Machine state mirrored by the predictor
  logic [63:0] gpr [0:10];
  logic [15:0] cur_pc;
  logic [7:0]  stk_mem [0:STACK_BYTES-1];
  logic [7:0]  ctx_mem [0:CTX_BYTES-1];
  int unsigned ctx_limit;

  result_t     pending_results [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit          calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] swap_bytes(logic [63:0] v, int n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r = (r << 8) | ((v >> (8 * i)) & 64'hff);
    return r;
  endfunction

  function automatic bit alu_op(logic [3:0] code, bit wide, logic [63:0] a, logic [63:0] b,
                                output logic [63:0] r);
    logic [63:0] m;
    logic [5:0]  sh;
    m  = wide ? '1 : 64'hffff_ffff;
    sh = wide ? b[5:0] : {1'b0, b[4:0]};
    a  = a & m;
    b  = b & m;
    r  = '0;
    case (code)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_DIV:  begin
        if (b == 64'd0) return 1'b0;
        r = a / b;
      end
      OP_OR:   r = a | b;
      OP_AND:  r = a & b;
      OP_LSH:  r = a << sh;
      OP_RSH:  r = a >> sh;
      OP_NEG:  r = 64'd0 - a;
      OP_MOD:  begin
        if (b == 64'd0) return 1'b0;
        r = a % b;
      end
      OP_XOR:  r = a ^ b;
      OP_MOV:  r = b;
      OP_ARSH: r = wide ? $signed(a) >>> sh : $signed(sext32(a[31:0])) >>> sh;
      default: return 1'b0;
    endcase
    r = r & m;
    return 1'b1;
  endfunction

  function automatic bit jump_taken(logic [3:0] code, logic [63:0] a, logic [63:0] b);
    case (code)
      J_EQ:    return a == b;
      J_GT:    return a > b;
      J_GE:    return a >= b;
      J_SET:   return (a & b) != 64'd0;
      J_NE:    return a != b;
      J_SGT:   return $signed(a) > $signed(b);
      J_SGE:   return $signed(a) >= $signed(b);
      J_LT:    return a < b;
      J_LE:    return a <= b;
      J_SLT:   return $signed(a) < $signed(b);
      default: return $signed(a) <= $signed(b);
    endcase
  endfunction

  // region 0 is the context, 1 the stack
  function automatic bit find_region(logic [63:0] addr, int unsigned size,
                                     output bit region, output int unsigned mo);
    logic [63:0] rel, lim, sz;
    region = 1'b0;
    mo     = 0;
    lim    = 64'(ctx_limit);
    sz     = 64'(size);
    if (addr < lim && sz <= lim - addr) begin
      mo = 32'(addr);
      return 1'b1;
    end
    rel = addr - STACK_BASE;
    if (addr >= STACK_BASE && rel < 64'(STACK_BYTES) && sz <= 64'(STACK_BYTES) - rel) begin
      region = 1'b1;
      mo     = 32'(rel);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] run_instruction(instr_t it, output logic [63:0] rv,
                                                 output logic [31:0] helper);
    logic [2:0]  cls;
    logic [3:0]  code;
    bit          use_src, wide, region;
    logic [63:0] off64, imm64, b, res, addr;
    logic [15:0] npc;
    int unsigned size, mo;
    cls     = it.opcode[2:0];
    code    = it.opcode[7:4];
    use_src = it.opcode[3];
    off64   = {{48{it.offs[15]}}, it.offs};
    imm64   = sext32(it.imm);
    npc     = cur_pc + 16'd1;
    rv      = '0;
    helper  = '0;
    if (cls == CLS_ALU || cls == CLS_ALU64) begin
      wide = cls == CLS_ALU64;
      if (it.dst > LAST_REG) return ST_FAULT;
      if (code == OP_END) begin
        if (wide) return ST_FAULT;
        res = gpr[it.dst];
        if (it.imm == 32'd16) res = use_src ? swap_bytes(res, 2) : res & 64'hffff;
        else if (it.imm == 32'd32) res = use_src ? swap_bytes(res, 4) : res & 64'hffff_ffff;
        else if (it.imm == 32'd64) res = use_src ? swap_bytes(res, 8) : res;
        gpr[it.dst] = res;
      end else begin
        if (code == OP_NEG && use_src) return ST_FAULT;
        if (use_src) begin
          if (it.src > LAST_REG) return ST_FAULT;
          b = gpr[it.src];
        end else begin
          b = imm64;
        end
        if (!alu_op(code, wide, gpr[it.dst], b, res)) return ST_FAULT;
        gpr[it.dst] = res;
      end
    end else if (cls == CLS_LD || cls == CLS_ST || cls == CLS_STX) begin
      if (it.opcode[7:5] != MODE_MEM || it.dst > LAST_REG) return ST_FAULT;
      if (cls != CLS_ST && it.src > LAST_REG) return ST_FAULT;
      case (it.opcode[4:3])
        2'd0:    size = 4;
        2'd1:    size = 2;
        2'd2:    size = 1;
        default: size = 8;
      endcase
      addr = (cls == CLS_LD ? gpr[it.src] : gpr[it.dst]) + off64;
      if (!find_region(addr, size, region, mo)) return ST_FAULT;
      if (cls == CLS_LD) begin
        res = '0;
        for (int i = int'(size) - 1; i >= 0; i--)
          res = (res << 8) | {56'd0, (region ? stk_mem[mo + i] : ctx_mem[mo + i])};
        gpr[it.dst] = res;
      end else begin
        b = (cls == CLS_ST) ? imm64 : gpr[it.src];
        for (int i = 0; i < int'(size); i++) begin
          if (region) stk_mem[mo + i] = b[8*i +: 8];
          else ctx_mem[mo + i] = b[8*i +: 8];
        end
      end
    end else if (it.opcode == OPC_LDDW) begin
      if (it.dst > LAST_REG) return ST_FAULT;
      gpr[it.dst] = {it.imm_hi, it.imm};
      npc = cur_pc + 16'd2;
    end else if (cls == CLS_JMP) begin
      if (it.opcode == OPC_JA) begin
        npc = npc + it.offs;
      end else if (it.opcode == OPC_CALL) begin
        helper = it.imm;
        cur_pc = npc;
        return ST_CALL;
      end else if (it.opcode == OPC_EXIT) begin
        rv = gpr[0];
        return ST_EXIT;
      end else begin
        if (code == J_JA || code == J_CALL || code == J_EXIT || code >= 4'he) return ST_FAULT;
        if (it.dst > LAST_REG || (use_src && it.src > LAST_REG)) return ST_FAULT;
        b = use_src ? gpr[it.src] : imm64;
        if (jump_taken(code, gpr[it.dst], b)) npc = npc + it.offs;
      end
    end else begin
      return ST_FAULT;
    end
    cur_pc = npc;
    return ST_RUN;
  endfunction

  function automatic result_t predict_result(instr_t it);
    result_t r;
    r = '{default: '0};
    case (it.action)
      ACT_EXEC: begin
        r.status = run_instruction(it, r.rv, r.helper);
        if (r.status == ST_FAULT) begin
          r.rv     = '1;
          r.helper = '0;
        end
      end
      ACT_SETREG: if (it.dst <= LAST_REG) gpr[it.dst] = it.value;
      ACT_CTXWR:  ctx_mem[it.cidx] = it.value[7:0];
      default:    if (it.dst <= LAST_REG) r.rv = gpr[it.dst];
    endcase
    r.pc = cur_pc;
    return r;
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        e = pending_results.pop_front();
        if (next_pc_o !== e.pc || status_o !== e.status || result_value_o !== e.rv ||
            helper_index_o !== e.helper) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp pc %h st %0d rv %h hi %h, got pc %h st %0d rv %h hi %h",
                     cycle_count, e.pc, e.status, e.rv, e.helper,
                     next_pc_o, status_o, result_value_o, helper_index_o);
        end
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = int'($urandom_range(1, 9));
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_item(instr_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= it.action;
    opcode_i    <= it.opcode;
    dst_reg_i   <= it.dst;
    src_reg_i   <= it.src;
    offset_i    <= it.offs;
    imm_i       <= it.imm;
    imm_high_i  <= it.imm_hi;
    value_i     <= it.value;
    ctx_index_i <= it.cidx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(it));
  endtask

  // Unused fields carry random bits
  function automatic instr_t mk(logic [1:0] action, logic [7:0] opcode, logic [3:0] dst,
                                logic [3:0] src, logic [15:0] offs, logic [31:0] imm);
    instr_t it;
    it.action = action;
    it.opcode = opcode;
    it.dst    = dst;
    it.src    = src;
    it.offs   = offs;
    it.imm    = imm;
    it.imm_hi = $urandom;
    it.value  = {$urandom, $urandom};
    it.cidx   = 8'($urandom);
    return it;
  endfunction

  task automatic set_reg(logic [3:0] idx, logic [63:0] v);
    instr_t it;
    it = mk(ACT_SETREG, 8'($urandom), idx, 4'($urandom), 16'($urandom), $urandom);
    it.value = v;
    send_item(it);
  endtask

  task automatic exec(logic [7:0] opcode, logic [3:0] dst, logic [3:0] src,
                      logic [15:0] offs, logic [31:0] imm);
    send_item(mk(ACT_EXEC, opcode, dst, src, offs, imm));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_ctx_len(logic [8:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    ctx_len_i   <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ctx_limit = (32'(v) > CTX_BYTES) ? CTX_BYTES : 32'(v);
  endtask

  // Every stack byte written once so later loads never see undefined data
  task automatic test_stack_fill();
    for (int k = 1; k <= int'(STACK_BYTES / 8); k++)
      exec({MODE_MEM, 2'b11, CLS_ST}, 4'd10, 4'd0, 16'(-8 * k), $urandom);
  endtask

  task automatic test_register_actions();
    send_item(mk(ACT_RDREG, 8'($urandom), 4'd10, 4'($urandom), 16'($urandom), $urandom));
    set_reg(4'd13, '1);                                   // ignored index
    send_item(mk(ACT_RDREG, 8'($urandom), 4'd12, 4'($urandom), 16'($urandom), $urandom));
    set_reg(4'd2, 64'h8000_0000_0000_0001);
  endtask

  task automatic test_alu_and_swaps();
    exec(OPC_LDDW, 4'd1, 4'd0, 16'd0, 32'hdead_beef);     // upper word random
    exec({OP_LSH, 1'b0, CLS_ALU64}, 4'd1, 4'd0, 16'd0, 32'd70);   // count masked
    exec({OP_ARSH, 1'b1, CLS_ALU}, 4'd2, 4'd1, 16'd0, 32'd0);
    exec({OP_END, 1'b1, CLS_ALU}, 4'd1, 4'd0, 16'd0, 32'd16);     // big endian
    exec({OP_END, 1'b1, CLS_ALU}, 4'd2, 4'd0, 16'd0, 32'd64);
    exec({OP_END, 1'b0, CLS_ALU}, 4'd2, 4'd0, 16'd0, 32'd32);
    exec({OP_END, 1'b1, CLS_ALU}, 4'd2, 4'd0, 16'd0, 32'd8);      // unchanged
    exec({OP_MUL, 1'b0, CLS_ALU64}, 4'd3, 4'd0, 16'd0, 32'h8000_0000);
  endtask

  task automatic test_faults();
    exec({OP_DIV, 1'b0, CLS_ALU64}, 4'd1, 4'd0, 16'd0, 32'd0);
    set_reg(4'd4, 64'h1_0000_0000);                       // zero in the low word
    exec({OP_MOD, 1'b1, CLS_ALU}, 4'd1, 4'd4, 16'd0, 32'd0);
    exec({OP_END, 1'b1, CLS_ALU64}, 4'd1, 4'd0, 16'd0, 32'd16);
    exec(8'h00, 4'd0, 4'd0, 16'd0, 32'd0);
    exec(8'hff, 4'd15, 4'd15, 16'h7fff, 32'h7fff_ffff);
    exec({OP_ADD, 1'b1, CLS_ALU64}, 4'd11, 4'd0, 16'd0, 32'd1);
    exec({MODE_MEM, 2'b00, CLS_LD}, 4'd0, 4'd5, 16'd0, 32'd0);     // empty context
    exec({MODE_MEM, 2'b11, CLS_STX}, 4'd10, 4'd1, 16'hfffc, 32'd0); // crosses stack top
  endtask

  task automatic test_jumps_call_exit();
    exec({J_GT, 1'b0, CLS_JMP}, 4'd0, 4'd0, 16'd5, 32'hffff_ffff); // imm sign-extended
    exec(OPC_JA, 4'd0, 4'd0, 16'h8000, 32'd0);
    exec({MODE_MEM, 2'b11, CLS_LD}, 4'd6, 4'd10, 16'hfff8, 32'd0);
    exec(OPC_CALL, 4'd0, 4'd0, 16'd0, 32'hffff_ffff);
    exec(OPC_EXIT, 4'd0, 4'd0, 16'd0, 32'd0);
  endtask

  // Result side held off so the queue fills and the input stalls
  task automatic test_backpressure();
    calm = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 10; i++)
      exec({OP_ADD, 1'b0, CLS_ALU64}, 4'($urandom_range(0, 9)), 4'd0, 16'd0, $urandom);
    calm = 1'b0;
  endtask

  function automatic logic [31:0] pick_imm();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 70) : $urandom;
  endfunction

  task automatic test_random_phase(int n, bit calm_tail);
    logic [3:0] jcodes [10] = '{J_EQ, J_GT, J_GE, J_SET, J_NE, J_SGT, J_SGE, J_LT, J_LE, J_SLT};
    int         k;
    logic [3:0] code, rb;
    bit         wide;
    logic [2:0] cls;
    instr_t     it;
    for (int i = 0; i < n; i++) begin
      if (calm_tail && i == n - 100) calm = 1'b1;
      if (i % 60 == 0) set_reg(4'd10, R10_RESET);
      k = int'($urandom_range(0, 99));
      if (k < 25) begin
        wide = 1'($urandom_range(0, 1));
        code = 4'($urandom_range(0, wide ? 12 : 13));
        it = mk(ACT_EXEC, {code, 1'($urandom), wide ? CLS_ALU64 : CLS_ALU},
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 10)), 16'($urandom),
                pick_imm());
        if (code == OP_END) it.imm = 32'(16 << $urandom_range(0, 3));
        send_item(it);
      end else if (k < 40) begin
        cls = 3'($urandom_range(CLS_LD, CLS_STX));
        exec({MODE_MEM, 2'($urandom), cls}, cls == CLS_LD ? 4'($urandom_range(0, 9)) : 4'd10,
             cls == CLS_LD ? 4'd10 : 4'($urandom_range(0, 10)),
             16'(-$urandom_range(1, 520)), $urandom);
      end else if (k < 50) begin
        rb = 4'($urandom_range(1, 9));
        cls = 3'($urandom_range(CLS_LD, CLS_STX));
        set_reg(rb, 64'($urandom_range(0, 264)));
        exec({MODE_MEM, 2'($urandom), cls}, cls == CLS_LD ? 4'($urandom_range(0, 9)) : rb,
             cls == CLS_LD ? rb : 4'($urandom_range(0, 10)),
             16'($urandom_range(0, 16) - 8), $urandom);
      end else if (k < 58) begin
        exec({jcodes[$urandom_range(0, 9)], 1'($urandom), CLS_JMP},
             4'($urandom_range(0, 10)), 4'($urandom_range(0, 10)),
             $urandom_range(0, 1) ? 16'($urandom_range(0, 40) - 20) : 16'($urandom), pick_imm());
      end else if (k < 63) begin
        exec(OPC_LDDW, 4'($urandom_range(0, 10)), 4'($urandom), 16'($urandom), $urandom);
      end else if (k < 66) begin
        exec(OPC_CALL, 4'($urandom), 4'($urandom), 16'($urandom), $urandom);
      end else if (k < 69) begin
        exec(OPC_EXIT, 4'($urandom), 4'($urandom), 16'($urandom), $urandom);
      end else if (k < 75) begin
        set_reg(4'($urandom_range(0, 9)),
                $urandom_range(0, 1) ? 64'($urandom_range(0, 10)) : {$urandom, $urandom});
      end else if (k < 80) begin
        send_item(mk(ACT_CTXWR, 8'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                     $urandom));
      end else if (k < 85) begin
        send_item(mk(ACT_RDREG, 8'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                     $urandom));
      end else begin
        send_item(mk(2'($urandom), 8'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                     $urandom));
      end
    end
  endtask

  // ----------------------------------------------------------------- sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    ctx_len_i   = '0;
    in_valid_i  = 1'b0;
    action_i    = '0;
    opcode_i    = '0;
    dst_reg_i   = '0;
    src_reg_i   = '0;
    offset_i    = '0;
    imm_i       = '0;
    imm_high_i  = '0;
    value_i     = '0;
    ctx_index_i = '0;
    mismatches  = 0;
    cycle_count = 0;
    hold_left   = 0;
    calm        = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    gpr[10]   = R10_RESET;
    cur_pc    = '0;
    ctx_limit = 0;
    foreach (ctx_mem[i]) ctx_mem[i] = '0;
    foreach (stk_mem[i]) stk_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_ctx_len(9'd0);
    test_stack_fill();
    test_register_actions();
    test_alu_and_swaps();
    test_faults();
    test_jumps_call_exit();
    test_backpressure();

    write_ctx_len(9'd256);
    test_random_phase(160, 1'b0);
    write_ctx_len(9'd511);
    test_random_phase(140, 1'b0);
    write_ctx_len(9'd1);
    test_random_phase(120, 1'b0);
    write_ctx_len(9'($urandom_range(2, 255)));
    test_random_phase(140, 1'b0);
    write_ctx_len(9'd0);
    test_random_phase(160, 1'b1);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
